FILE: hdl/keyboard_latch_with_fifo_defines.svh
// Assertion macros shared by the keyboard latch checker.
// Needs a clock named clock and a synchronous reset named reset in scope.
`ifndef KEYBOARD_LATCH_WITH_FIFO_DEFINES_SVH
`define KEYBOARD_LATCH_WITH_FIFO_DEFINES_SVH

// Same-cycle implication, skipped while reset is high.
`define KLWF_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("klwf: same-cycle check failed");

// Next-cycle implication, skipped while reset is high.
`define KLWF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("klwf: next-cycle check failed");

`endif

FILE: hdl/klwf_pkg.sv
// Package for the keyboard latch with FIFO: codes, constants, cell control
// struct and the key translation function. No dependencies.
`default_nettype none

package klwf_pkg;

   localparam int KLWF_QUEUE_DEPTH = 8;

   // transaction command codes
   localparam logic [1:0] CMD_KEY   = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_WRITE = 2'd2;

   // register indexes on the csr port
   localparam logic CSR_CAPS_LOCK_ON = 1'b0;
   localparam logic CSR_KEYS_LOCKED  = 1'b1;

   // offset where the strobe clears and nothing is popped
   localparam logic [4:0] OFS_CLEAR = 5'd16;

   localparam logic [7:0] STROBE_BIT = 8'h80;
   localparam logic [7:0] CASE_BIT   = 8'h20;
   localparam logic [7:0] LETTER_A   = 8'h41;
   localparam logic [7:0] LETTER_Z   = 8'h5A;
   localparam logic [7:0] CTRL_BASE  = LETTER_A - 8'd1;

   // broadcast to every cell of the queue chain
   typedef struct packed {
      logic       push;
      logic       pop;
      logic [7:0] key;
   } cell_ctrl_type;

   // control letters to 1..26, fold uppercase when caps lock is off
   function automatic logic [7:0] translate_key(input logic [7:0] key,
                                                input logic       ctrl,
                                                input logic       caps);
      logic       upper;
      logic       lower;
      logic [7:0] c;
      upper = (key >= LETTER_A) && (key <= LETTER_Z);
      lower = (key >= (LETTER_A | CASE_BIT)) && (key <= (LETTER_Z | CASE_BIT));
      c     = key;
      if (ctrl && (upper || lower)) begin
         c = (key & ~CASE_BIT) - CTRL_BASE;
      end else if (!caps && upper) begin
         c = key | CASE_BIT;
      end
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/klwf_cell.sv
// One slot of the shift-down key queue.
// Depends on klwf_pkg (cell_ctrl_type).
`default_nettype none

module klwf_cell
   import klwf_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cell_ctrl_type ctrl,
   input  wire logic          up_valid,   // neighbour nearer the tail
   input  wire logic [7:0]    up_key,
   input  wire logic          down_valid, // neighbour nearer the head
   output logic               valid,
   output logic [7:0]         key
);

   logic       valid_ff, valid_in;
   logic [7:0] key_ff, key_in;

   // pop: everything moves one slot towards the head
   // push: lands in the first empty slot above a filled one, or in an empty head
   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      if (ctrl.pop) begin
         valid_in = up_valid;
         key_in   = up_key;
      end else if (ctrl.push && !valid_ff && down_valid) begin
         valid_in = 1'b1;
         key_in   = ctrl.key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      key_ff <= key_in;
   end

   assign valid = valid_ff;
   assign key   = key_ff;

endmodule

`default_nettype wire

FILE: hdl/keyboard_latch_with_fifo.sv
// Keyboard data latch with strobe, fed by a queue built from a chain of cells.
// Depends on klwf_pkg and klwf_cell.
// Use:
//   req_* carries one transaction: a key event (cmd key) or a bus access
//   (cmd read / write) at io_offset in a 32-byte window. Translated key
//   presses enter the queue; a read at offsets 0..15 moves the oldest key
//   into the latch when the strobe is clear and returns latch | strobe<<7.
//   A read at offset 16 clears the strobe and returns the bare latch;
//   reads above 16 return 0. Writes at 16..31 clear the strobe.
//   rsp_* carries one byte for every read, nothing for other transactions.
//   csr_* writes caps_lock_on (index 0) or keys_locked (index 1), one per write.
// Timing:
//   Every transaction is decoded and retired in the cycle it is accepted;
//   a read's byte appears on rsp_* the following cycle. One transaction
//   per cycle is sustained, set by the single output register.
//   When rsp_ready is low with a byte waiting, req_ready drops until the
//   byte is taken; nothing is lost or repeated.
// Reset:
//   Synchronous: queue empty, latch 0, strobe clear, caps lock on,
//   keys unlocked, no byte pending.
`default_nettype none

module keyboard_latch_with_fifo
   import klwf_pkg::*;
#(
   parameter int QUEUE_DEPTH = KLWF_QUEUE_DEPTH
)
(
   input  wire logic       clock,
   input  wire logic       reset,
   // request channel
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_cmd,
   input  wire logic [4:0] req_io_offset,
   input  wire logic [7:0] req_key_value,
   input  wire logic       req_key_down,
   input  wire logic       req_ctrl_held,
   input  wire logic       req_system_held,
   input  wire logic       req_altgr_held,
   // response channel
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_read_data,
   // configuration writes
   input  wire logic       csr_we,
   input  wire logic       csr_index,
   input  wire logic       csr_wdata
);

   logic          caps_lock_on_ff, keys_locked_ff;
   logic          key_latch_en;
   logic [7:0]    key_latch_ff, key_latch_in;
   logic          strobe_ff, strobe_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_data_ff, rsp_data_in;

   logic          req_accept;
   logic          is_key, is_read, is_write;
   logic          data_offset;   // offsets 0..15
   logic          queue_full;
   cell_ctrl_type cell_ctrl;

   logic [QUEUE_DEPTH-1:0] cell_valid;
   logic [7:0]             cell_key [QUEUE_DEPTH];

   // output slot is free, or is being emptied this cycle
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   assign is_key      = req_accept && (req_cmd == CMD_KEY);
   assign is_read     = req_accept && (req_cmd == CMD_READ);
   assign is_write    = req_accept && (req_cmd == CMD_WRITE);
   assign data_offset = !req_io_offset[4];

   // the tail cell holding a key means every cell does
   assign queue_full = cell_valid[QUEUE_DEPTH-1];

   always_comb begin
      cell_ctrl.push = is_key && req_key_down && !req_altgr_held && !req_system_held
                       && !keys_locked_ff && !queue_full;
      cell_ctrl.pop  = is_read && data_offset && !strobe_ff && cell_valid[0];
      cell_ctrl.key  = translate_key(req_key_value, req_ctrl_held, caps_lock_on_ff);
   end

   // queue: cell 0 is the head, data shifts down one cell on a pop
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic       up_valid;
      logic [7:0] up_key;
      logic       down_valid;

      if (i == QUEUE_DEPTH - 1) begin : g_top
         assign up_valid = 1'b0;
         assign up_key   = '0;
      end else begin : g_mid
         assign up_valid = cell_valid[i+1];
         assign up_key   = cell_key[i+1];
      end

      if (i == 0) begin : g_head
         assign down_valid = 1'b1;
      end else begin : g_rest
         assign down_valid = cell_valid[i-1];
      end

      klwf_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .up_valid   (up_valid),
         .up_key     (up_key),
         .down_valid (down_valid),
         .valid      (cell_valid[i]),
         .key        (cell_key[i])
      );
   end

   // latch, strobe and the read byte
   always_comb begin
      key_latch_en = cell_ctrl.pop;
      key_latch_in = cell_key[0];
      strobe_in    = strobe_ff;
      rsp_data_in  = rsp_data_ff;

      if (cell_ctrl.pop) begin
         strobe_in = 1'b1;
      end else if ((is_read && (req_io_offset == OFS_CLEAR))
                   || (is_write && !data_offset)) begin
         strobe_in = 1'b0;
      end

      if (is_read) begin
         if (cell_ctrl.pop) begin
            rsp_data_in = cell_key[0] | STROBE_BIT;
         end else if (data_offset) begin
            rsp_data_in = key_latch_ff | (strobe_ff ? STROBE_BIT : 8'h00);
         end else if (req_io_offset == OFS_CLEAR) begin
            rsp_data_in = key_latch_ff;
         end else begin
            rsp_data_in = '0;  // nothing decodes above the clear offset
         end
      end

      if (is_read) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         caps_lock_on_ff <= 1'b1;
         keys_locked_ff  <= 1'b0;
         key_latch_ff    <= '0;
         strobe_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_CAPS_LOCK_ON: caps_lock_on_ff <= csr_wdata;
               CSR_KEYS_LOCKED:  keys_locked_ff  <= csr_wdata;
               default:          ;
            endcase
         end
         if (key_latch_en) begin
            key_latch_ff <= key_latch_in;
         end
         strobe_ff    <= strobe_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

endmodule

`default_nettype wire

FILE: hdl/klwf_checker.sv
// Port-level checks for keyboard_latch_with_fifo, bound to the top level.
// Depends on klwf_pkg and keyboard_latch_with_fifo_defines.svh.
`default_nettype none
`include "keyboard_latch_with_fifo_defines.svh"

module klwf_checker
   import klwf_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic [1:0] req_cmd,
   input wire logic [4:0] req_io_offset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_read_data
);

   logic read_taken;
   logic other_taken;

   assign read_taken  = req_valid && req_ready && (req_cmd == CMD_READ);
   assign other_taken = req_valid && req_ready && (req_cmd != CMD_READ);

   // a waiting byte holds still
   `KLWF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_data))
   // an empty output slot never blocks requests
   `KLWF_ASSERT_NOW(a_ready_when_empty, !rsp_valid, req_ready)
   // reads above the clear offset answer zero
   `KLWF_ASSERT_NEXT(a_unmapped_zero, read_taken && (req_io_offset > OFS_CLEAR), rsp_valid && (rsp_read_data == 8'h00))
   // key events, writes and the unused code make no byte when none is waiting
   `KLWF_ASSERT_NEXT(a_no_spurious_rsp, other_taken && !rsp_valid, !rsp_valid)

endmodule

bind keyboard_latch_with_fifo klwf_checker u_klwf_checker (.*);

`default_nettype wire

FILE: tb/sv/kb_latch_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the keyboard latch: follows req/rsp/csr traffic, keeps its own copy of
// the latch, strobe, key FIFO and settings, and compares every read byte in order.
// Depends on klwf_pkg for command codes, register indexes and character constants.
module kb_latch_checker
   import klwf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [1:0] req_cmd,
   input  logic [4:0] req_io_offset,
   input  logic [7:0] req_key_value,
   input  logic       req_key_down,
   input  logic       req_ctrl_held,
   input  logic       req_system_held,
   input  logic       req_altgr_held,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_read_data,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic       csr_wdata,
   output int         mismatch_total,
   output int         bytes_outstanding,
   output int         bytes_compared
);

   localparam int MAX_PRINTED = 100;

   logic       caps_on;
   logic       locked;
   logic [7:0] latch_copy;
   logic       strobe_copy;
   logic [7:0] key_fifo[$];
   logic [7:0] read_bytes_due[$];
   logic [7:0] due_byte;

   initial begin
      mismatch_total    = 0;
      bytes_outstanding = 0;
      bytes_compared    = 0;
   end

   // letter test on the folded code: A..Z and a..z both land in A..Z
   function automatic logic [7:0] keyed_char(input logic [7:0] code, input logic ctrl,
                                             input logic caps);
      logic [7:0] folded;
      logic       letter;
      folded = code & ~CASE_BIT;
      letter = (folded >= LETTER_A) && (folded <= LETTER_Z);
      if (ctrl && letter) begin
         return folded - (LETTER_A - 8'd1);
      end
      if (!caps && code >= LETTER_A && code <= LETTER_Z) begin
         return code | CASE_BIT;
      end
      return code;
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] want,
                                  input logic [7:0] got);
      if (mismatch_total < MAX_PRINTED) begin
         $display("%0t ns: %s: expected %02h, got %02h", $time, what, want, got);
      end
      mismatch_total++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         caps_on     = 1'b1;
         locked      = 1'b0;
         latch_copy  = 8'h00;
         strobe_copy = 1'b0;
         key_fifo.delete();
         read_bytes_due.delete();
      end else begin
         // a read's byte is registered before it leaves, so compare before predicting
         if (rsp_valid && rsp_ready) begin
            bytes_compared++;
            if (read_bytes_due.size() == 0) begin
               report_mismatch("read byte with none due", 8'h00, rsp_read_data);
            end else begin
               due_byte = read_bytes_due.pop_front();
               if (rsp_read_data !== due_byte) begin
                  report_mismatch("read_data", due_byte, rsp_read_data);
               end
            end
         end

         if (csr_we) begin
            case (csr_index)
               CSR_CAPS_LOCK_ON: caps_on = csr_wdata;
               CSR_KEYS_LOCKED:  locked  = csr_wdata;
               default: ;
            endcase
         end

         if (req_valid && req_ready) begin
            case (req_cmd)
               CMD_KEY: begin
                  if (req_key_down && !req_system_held && !req_altgr_held && !locked &&
                      key_fifo.size() < KLWF_QUEUE_DEPTH) begin
                     key_fifo.push_back(keyed_char(req_key_value, req_ctrl_held, caps_on));
                  end
               end
               CMD_READ: begin
                  if (req_io_offset < OFS_CLEAR) begin
                     if (!strobe_copy && key_fifo.size() != 0) begin
                        latch_copy  = key_fifo.pop_front();
                        strobe_copy = 1'b1;
                     end
                     read_bytes_due.push_back(latch_copy | (strobe_copy ? STROBE_BIT : 8'h00));
                  end else if (req_io_offset == OFS_CLEAR) begin
                     strobe_copy = 1'b0;
                     read_bytes_due.push_back(latch_copy);
                  end else begin
                     read_bytes_due.push_back(8'h00);
                  end
               end
               CMD_WRITE: begin
                  if (req_io_offset >= OFS_CLEAR) begin
                     strobe_copy = 1'b0;
                  end
               end
               default: ;
            endcase
         end
      end
      bytes_outstanding <= read_bytes_due.size();
   end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Top of the keyboard latch testbench: clock, reset, transaction and csr stimulus,
// response back-pressure and the verdict. Needs klwf_pkg, the block and kb_latch_checker.
module tb;
   import klwf_pkg::*;

   // one request transaction, every field at its port width
   typedef struct packed {
      logic [1:0] cmd;
      logic [4:0] offset;
      logic [7:0] key;
      logic       down;
      logic       ctrl;
      logic       sys;
      logic       altgr;
   } kb_txn_type;

   localparam int TXN_BITS = $bits(kb_txn_type);

   // the command code the block has no use for
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_ITEMS   = 300;   // transactions per phase
   localparam int PAUSE_AT      = 150;   // mid-phase hold-off until all bytes are back
   localparam int CALM_PHASE    = 4;     // neither side idles in this phase

   logic       clock           = 1'b0;
   logic       reset           = 1'b1;
   logic       req_valid       = 1'b0;
   logic [1:0] req_cmd         = CMD_KEY;
   logic [4:0] req_io_offset   = 5'd0;
   logic [7:0] req_key_value   = 8'h00;
   logic       req_key_down    = 1'b0;
   logic       req_ctrl_held   = 1'b0;
   logic       req_system_held = 1'b0;
   logic       req_altgr_held  = 1'b0;
   logic       rsp_ready       = 1'b0;
   logic       csr_we          = 1'b0;
   logic       csr_index       = CSR_CAPS_LOCK_ON;
   logic       csr_wdata       = 1'b0;
   logic       req_ready;
   logic       rsp_valid;
   logic [7:0] rsp_read_data;

   logic calm       = 1'b0;   // suppresses idling on both sides
   logic locked_now = 1'b0;   // our note of keys_locked, only for counting work

   int mismatch_total;
   int bytes_outstanding;
   int bytes_compared;
   int sent_total      = 0;
   int effective_total = 0;
   int settings_used   = 0;

   keyboard_latch_with_fifo dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_io_offset  (req_io_offset),
      .req_key_value  (req_key_value),
      .req_key_down   (req_key_down),
      .req_ctrl_held  (req_ctrl_held),
      .req_system_held(req_system_held),
      .req_altgr_held (req_altgr_held),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_data  (rsp_read_data),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   kb_latch_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_io_offset    (req_io_offset),
      .req_key_value    (req_key_value),
      .req_key_down     (req_key_down),
      .req_ctrl_held    (req_ctrl_held),
      .req_system_held  (req_system_held),
      .req_altgr_held   (req_altgr_held),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_data    (rsp_read_data),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatch_total   (mismatch_total),
      .bytes_outstanding(bytes_outstanding),
      .bytes_compared   (bytes_compared)
   );

   // 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // receiver stalls in roughly a quarter of cycles unless things are calm
   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(0, 99) >= 24);
   end

   // hard stop in case a handshake never completes
   initial begin
      #2_000_000;
      $display("timeout waiting for the block");
      $display("CHECKS FAILED");
      $finish;
   end

   // key event; the offset is don't-care so it is left random
   function automatic kb_txn_type key_txn(input logic [7:0] code, input logic down,
                                          input logic ctrl, input logic sys,
                                          input logic altgr);
      kb_txn_type t;
      t       = TXN_BITS'($urandom);
      t.cmd   = CMD_KEY;
      t.key   = code;
      t.down  = down;
      t.ctrl  = ctrl;
      t.sys   = sys;
      t.altgr = altgr;
      return t;
   endfunction

   // bus access; the key fields are don't-care so they are left random
   function automatic kb_txn_type bus_txn(input logic [1:0] cmd, input logic [4:0] offset);
      kb_txn_type t;
      t        = TXN_BITS'($urandom);
      t.cmd    = cmd;
      t.offset = offset;
      return t;
   endfunction

   // Mostly well-formed traffic: key presses (largely letters) against data reads
   // so the FIFO fills and drains, plus strobe clears. The rest is noise: releases,
   // modifier-held keys, reads with no device behind them, low writes, unused code.
   function automatic kb_txn_type random_txn();
      kb_txn_type t;
      int         pick;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         t = key_txn(8'($urandom), $urandom_range(0, 7) != 0, $urandom_range(0, 3) == 0,
                     $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
         if ($urandom_range(0, 9) < 6) begin
            t.key = 8'(LETTER_A + $urandom_range(0, 25));
            if ($urandom_range(0, 1) == 1) begin
               t.key = t.key | CASE_BIT;
            end
         end
      end else if (pick < 65) begin
         t = bus_txn(CMD_READ, 5'($urandom_range(0, 15)));
      end else if (pick < 78) begin
         t = bus_txn(CMD_READ, OFS_CLEAR);
      end else if (pick < 86) begin
         t = bus_txn(CMD_READ, 5'($urandom_range(17, 31)));
      end else if (pick < 95) begin
         t = bus_txn(CMD_WRITE, 5'($urandom_range(0, 31)));
      end else begin
         t = bus_txn(CMD_UNUSED, 5'($urandom_range(0, 31)));
      end
      return t;
   endfunction

   // does this transaction change state or produce a byte?
   function automatic bit counts_as_work(input kb_txn_type t);
      case (t.cmd)
         CMD_READ:  return 1'b1;
         CMD_WRITE: return t.offset >= OFS_CLEAR;
         CMD_KEY:   return t.down && !t.sys && !t.altgr && !locked_now;
         default:   return 1'b0;
      endcase
   endfunction

   // Drive one transaction and hold it until accepted. Valid is only dropped during
   // an idle gap, so back-to-back transactions never see valid fall and rise in one step.
   task automatic send(input kb_txn_type t);
      while (!calm && $urandom_range(0, 99) < 24) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= t.cmd;
      req_io_offset   <= t.offset;
      req_key_value   <= t.key;
      req_key_down    <= t.down;
      req_ctrl_held   <= t.ctrl;
      req_system_held <= t.sys;
      req_altgr_held  <= t.altgr;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_total++;
   endtask

   // Stop sending and let every read byte come back. The checker's count is registered,
   // hence the first edge. Spare edges at the end cover any key event or write
   // still being retired, since those give no byte to wait for.
   task automatic wait_for_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (bytes_outstanding != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // both registers one after the other; only ever called with the block quiet
   task automatic write_settings(input logic caps, input logic lock);
      csr_we    <= 1'b1;
      csr_index <= CSR_CAPS_LOCK_ON;
      csr_wdata <= caps;
      @(posedge clock);
      csr_index <= CSR_KEYS_LOCKED;
      csr_wdata <= lock;
      @(posedge clock);
      csr_we     <= 1'b0;
      locked_now = lock;
      settings_used++;
   endtask

   initial begin
      kb_txn_type t;
      int         phase;
      int         done;
      int         guard;
      bit         paused;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part, reset settings (caps lock on, keys unlocked).
      send(key_txn(LETTER_A, 1'b1, 1'b0, 1'b0, 1'b0));   // uppercase kept
      send(key_txn(8'h61,    1'b1, 1'b1, 1'b0, 1'b0));   // ctrl-a gives 1
      send(key_txn(LETTER_Z, 1'b1, 1'b1, 1'b0, 1'b0));   // ctrl-Z gives 26
      send(key_txn(8'h00,    1'b1, 1'b0, 1'b0, 1'b0));   // lowest code
      send(key_txn(8'hFF,    1'b1, 1'b1, 1'b1, 1'b0));   // system held: dropped
      send(key_txn(8'h71,    1'b1, 1'b0, 1'b0, 1'b1));   // alt-graph held: dropped
      send(key_txn(8'h78,    1'b0, 1'b0, 1'b0, 1'b0));   // release: ignored
      send(bus_txn(CMD_READ, 5'd0));                     // pops 'A', strobe set
      send(bus_txn(CMD_READ, 5'd15));                    // strobe set: no pop
      send(bus_txn(CMD_WRITE, 5'd5));                    // low write: ignored
      send(bus_txn(CMD_READ, OFS_CLEAR));                // clears strobe, bare latch
      send(bus_txn(CMD_READ, 5'd31));                    // nothing answers: zero
      send(bus_txn(CMD_READ, 5'd17));
      send(bus_txn(CMD_WRITE, OFS_CLEAR));               // clear with strobe already low
      send(bus_txn(CMD_READ, 5'd7));                     // pops the ctrl-a code
      send(bus_txn(CMD_WRITE, 5'd31));                   // high write clears strobe
      send(bus_txn(CMD_UNUSED, 5'($urandom)));
      // ctrl on codes just outside the letter ranges; the last two overflow the FIFO
      send(key_txn(8'h40, 1'b1, 1'b1, 1'b0, 1'b0));
      send(key_txn(8'h5B, 1'b1, 1'b1, 1'b0, 1'b0));
      send(key_txn(8'h60, 1'b1, 1'b1, 1'b0, 1'b0));
      send(key_txn(8'h7B, 1'b1, 1'b1, 1'b0, 1'b0));
      send(key_txn(8'hC1, 1'b1, 1'b1, 1'b0, 1'b0));
      send(key_txn(8'hE1, 1'b1, 1'b1, 1'b0, 1'b0));
      send(key_txn(8'h7F, 1'b1, 1'b1, 1'b0, 1'b0));
      send(key_txn(8'h80, 1'b1, 1'b1, 1'b0, 1'b0));

      // Random phases walk every combination of caps lock and key lock; phase 4
      // runs with no idling on either side.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_for_quiet();
         write_settings(phase[0], phase == 2 || phase == 3);
         calm <= (phase == CALM_PHASE);
         done   = 0;
         paused = 1'b0;
         while (done < PHASE_ITEMS) begin
            if (done == PAUSE_AT && !paused) begin
               wait_for_quiet();
               paused = 1'b1;
            end
            t = random_txn();
            send(t);
            done++;
            if (counts_as_work(t)) begin
               effective_total++;
            end
         end
      end
      calm <= 1'b0;

      // drain, bounded, then a short tail for anything still in flight
      req_valid <= 1'b0;
      @(posedge clock);
      guard = 0;
      while (bytes_outstanding != 0 && guard < 10000) begin
         @(posedge clock);
         guard++;
      end
      repeat (8) @(posedge clock);

      $display("Sent %0d transactions; %0d random ones did work across %0d phases",
               sent_total, effective_total, RANDOM_PHASES);
      $display("Settings written %0d times, all caps/lock pairs; %0d read bytes compared",
               settings_used, bytes_compared);
      if (mismatch_total == 0 && bytes_outstanding == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
